>>> sv/bhpq_pkg.sv
// shared codes for the binary heap priority queue
`default_nettype none
package bhpq_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  // register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_MAX_FIRST = 1'b0;  // word index of max_first

endpackage
`default_nettype wire

>>> sv/bhpq_ram.sv
// key store: one write port, two registered read ports
`default_nettype none
module bhpq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic [AW-1:0] ra0,
  input  wire logic [AW-1:0] ra1,
  output logic      [DW-1:0] rd0,
  output logic      [DW-1:0] rd1
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule
`default_nettype wire

>>> sv/binary_heap_priority_queue.sv
// binary heap priority queue top level: control sequencer around the key store
//
// input channel (in_valid/in_ready): one beat carries operation, key and position.
// operation insert puts key into the heap; remove takes out the entry at a
// one-based level-order position. output channel (out_valid/out_ready): one
// beat per input beat with status, removed_key, top_valid, top_key, entry_count.
// one item is worked at a time. rejected items (full, empty, bad position) go
// from the request check straight to the result state and then free the input.
// an insert or remove walks the heap one level at a time: each level has one
// key store read state, then one compare and write state, since each level
// waits for its read before it compares.
// the finished result sits in an output register; the next beat is accepted as
// soon as the result is loaded, even while the receiver stalls. a new result
// waits in its final state until the output register is free.
// reset (rst, synchronous) empties the heap and clears max_first; the key
// store itself is not cleared; entries beyond the count are never used.
// max_first lives at byte address 0 of the register port and must only be
// written while the queue is idle.
`default_nettype none
module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 32,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bhpq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [bhpq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [bhpq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  input  wire logic [KEY_BITS-1:0]                 key,
  input  wire logic [CW-1:0]                       position,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [1:0]                          status,
  output logic      [KEY_BITS-1:0]                 removed_key,
  output logic                                     top_valid,
  output logic      [KEY_BITS-1:0]                 top_key,
  output logic      [CW-1:0]                       entry_count
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;  // check the request, issue remove reads
  localparam logic [2:0] S_RM_CMP = 3'd2;  // removed key and last key arrive
  localparam logic [2:0] S_UP_RD  = 3'd3;  // read parent of the hole
  localparam logic [2:0] S_UP_CMP = 3'd4;  // compare with parent, move parent down
  localparam logic [2:0] S_DN_RD  = 3'd5;  // read both children of the hole
  localparam logic [2:0] S_DN_CMP = 3'd6;  // pick successor, move it up
  localparam logic [2:0] S_FIN    = 3'd7;  // load result register

  function automatic logic precedes(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b,
                                    input logic                mf);
    return mf ? (a > b) : (a < b);
  endfunction

  // one-based position to store address
  function automatic logic [AW-1:0] to_addr(input logic [CW:0] pos);
    logic [CW:0] d;
    d = pos - {{CW{1'b0}}, 1'b1};
    return d[AW-1:0];
  endfunction

  logic [2:0]          state;
  logic                max_first;
  logic                op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CW-1:0]       pos_r;
  logic [CW-1:0]       count;
  logic [CW-1:0]       p;          // current hole position
  logic [KEY_BITS-1:0] cur;        // key being sifted
  logic                first;      // first sift-up step of a remove
  logic [1:0]          st_r;
  logic [KEY_BITS-1:0] rem_r;
  logic [KEY_BITS-1:0] top_reg;    // copy of the root entry

  // key store ports
  logic                mem_we;
  logic [CW-1:0]       mem_wpos;
  logic [KEY_BITS-1:0] mem_wd;
  logic [AW-1:0]       mem_ra0;
  logic [AW-1:0]       mem_ra1;
  logic [KEY_BITS-1:0] rd0;
  logic [KEY_BITS-1:0] rd1;

  // sift decisions
  logic [CW:0]         l_pos;
  logic [CW:0]         r_pos;
  logic                has_l;
  logic                pick_r;
  logic [KEY_BITS-1:0] succ_key;
  logic [CW:0]         succ_pos;
  logic                up_before;
  logic                dn_before;
  logic                cfg_wr;
  logic                at_root;

  bhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (KEY_BITS)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (to_addr({1'b0, mem_wpos})),
    .wd  (mem_wd),
    .ra0 (mem_ra0),
    .ra1 (mem_ra1),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == bhpq_pkg::REG_MAX_FIRST)
                  ? {{(bhpq_pkg::APB_DATA_W-1){1'b0}}, max_first} : '0;

  assign in_ready = (state == S_IDLE);

  // children of the hole; rd0 holds the left, rd1 the right child in S_DN_CMP
  assign l_pos     = {p, 1'b0};
  assign r_pos     = l_pos + {{CW{1'b0}}, 1'b1};
  assign has_l     = (l_pos <= {1'b0, count});
  // a tie goes to the right child
  assign pick_r    = (r_pos <= {1'b0, count}) && !precedes(rd0, rd1, max_first);
  assign succ_key  = pick_r ? rd1 : rd0;
  assign succ_pos  = pick_r ? r_pos : l_pos;
  assign up_before = precedes(cur, rd0, max_first);
  assign dn_before = precedes(cur, succ_key, max_first);
  assign at_root   = (p == CW'(1));

  // key store access per state
  always_comb begin
    mem_we   = 1'b0;
    mem_wpos = p;
    mem_wd   = cur;
    mem_ra0  = to_addr({1'b0, pos_r});
    mem_ra1  = to_addr({1'b0, count});
    unique case (state)
      S_UP_RD: begin
        if (at_root) begin
          mem_we = !first;
        end else begin
          mem_ra0 = to_addr({2'b00, p[CW-1:1]});
        end
      end
      S_UP_CMP: begin
        // parent moves down into the hole, or the key settles here
        if (up_before) begin
          mem_we = 1'b1;
          mem_wd = rd0;
        end else begin
          mem_we = !first;
        end
      end
      S_DN_RD: begin
        mem_we  = !has_l;
        mem_ra0 = to_addr(l_pos);
        mem_ra1 = to_addr(r_pos);
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        mem_wd = dn_before ? cur : succ_key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we && (mem_wpos == CW'(1))) begin
      top_reg <= mem_wd;
    end
  end

  // payload of the request and the work registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= operation;
      key_r <= key;
      pos_r <= position;
    end
    unique case (state)
      S_START: begin
        rem_r <= '0;
        if (op_r == bhpq_pkg::OP_INSERT) begin
          if (count == CW'(CAPACITY)) begin
            st_r <= bhpq_pkg::ST_FULL;
          end else begin
            st_r <= bhpq_pkg::ST_OK;
          end
          cur <= key_r;
          p   <= count + CW'(1);
        end else begin
          if (count == '0) begin
            st_r <= bhpq_pkg::ST_EMPTY;
          end else if ((pos_r == '0) || (pos_r > count)) begin
            st_r <= bhpq_pkg::ST_BAD_POS;
          end else begin
            st_r <= bhpq_pkg::ST_OK;
          end
          p <= pos_r;
        end
      end
      S_RM_CMP: begin
        rem_r <= rd0;
        cur   <= rd1;
      end
      S_UP_CMP: begin
        if (up_before) begin
          p <= {1'b0, p[CW-1:1]};
        end
      end
      S_DN_CMP: begin
        if (!dn_before) begin
          p <= succ_pos[CW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      status      <= st_r;
      removed_key <= rem_r;
      top_valid   <= (count != '0);
      top_key     <= (count != '0) ? top_reg : '0;
      entry_count <= count;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      first     <= 1'b0;
      out_valid <= 1'b0;
      max_first <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == bhpq_pkg::REG_MAX_FIRST)) begin
        max_first <= pwdata[0];
      end
      // a result loaded this cycle keeps the output beat valid
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          first <= 1'b0;
          if (op_r == bhpq_pkg::OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              state <= S_FIN;
            end else begin
              count <= count + CW'(1);
              state <= S_UP_RD;
            end
          end else if ((count == '0) || (pos_r == '0) || (pos_r > count)) begin
            state <= S_FIN;
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          count <= count - CW'(1);
          // removing the last entry just drops it
          if (p == count) begin
            state <= S_FIN;
          end else begin
            first <= 1'b1;
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          if (at_root) begin
            first <= 1'b0;
            state <= first ? S_DN_RD : S_FIN;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          first <= 1'b0;
          if (up_before) begin
            state <= S_UP_RD;
          end else if (first) begin
            // moved-in last entry is not above its parent: sift down instead
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_RD: begin
          state <= has_l ? S_DN_CMP : S_FIN;
        end
        S_DN_CMP: begin
          state <= dn_before ? S_FIN : S_DN_RD;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the key store is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("key store written while idle");

  // a full result only comes with a full heap
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && (st_r == bhpq_pkg::ST_FULL)) |-> (count == CW'(CAPACITY)))
    else $error("full status with room left");

  // the count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((count == $past(count)) || (count == $past(count) + CW'(1))
                     || (count == $past(count) - CW'(1))))
    else $error("entry count jumped");

endmodule
`default_nettype wire

>>> tb/sv/binary_heap_priority_queue_tb.sv
// self-checking testbench for the binary heap priority queue
module binary_heap_priority_queue_tb;

  localparam int unsigned HEAP_DEPTH = 256;
  localparam int unsigned SETTLE_CYCLES = 40;   // longer than the slowest sift
  localparam int unsigned REG_UNUSED = 1;       // word index past the register list

  // one expected result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_key;
    logic        top_valid;
    logic [31:0] top_key;
    logic [8:0]  entry_count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst;

  // register port
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [bhpq_pkg::APB_ADDR_W-1:0]  paddr;
  logic [bhpq_pkg::APB_DATA_W-1:0]  pwdata;
  logic [bhpq_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;

  // input channel
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [31:0] key;
  logic [8:0]  position;

  // output channel
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] removed_key;
  logic        top_valid;
  logic [31:0] top_key;
  logic [8:0]  entry_count;

  // shadow copy of the heap, kept in step with every accepted beat
  logic [31:0]  shadow_keys [0:HEAP_DEPTH];
  int unsigned  shadow_count = 0;
  bit           shadow_max_first = 1'b0;

  heap_result_t pending_results [$];
  heap_result_t want_r;
  int unsigned  fail_count = 0;

  // pacing knobs for the source and the result sink
  bit           src_burst = 1'b0;
  bit           sink_burst = 1'b0;
  int unsigned  sink_hold = 0;

  binary_heap_priority_queue u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .key         (key),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .removed_key (removed_key),
    .top_valid   (top_valid),
    .top_key     (top_key),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // heap predictor
  // ---------------------------------------------------------------------------

  // strict ordering: a goes nearer the root than b
  function automatic bit ranks_ahead(input logic [31:0] a, input logic [31:0] b);
    return shadow_max_first ? (a > b) : (a < b);
  endfunction

  function automatic void sift_up(input int unsigned start);
    int unsigned p;
    int unsigned q;
    logic [31:0] t;
    bit          done;
    p = start;
    done = 1'b0;
    while (p > 1 && !done) begin
      q = p >> 1;
      if (!ranks_ahead(shadow_keys[p], shadow_keys[q])) begin
        done = 1'b1;
      end else begin
        t = shadow_keys[p];
        shadow_keys[p] = shadow_keys[q];
        shadow_keys[q] = t;
        p = q;
      end
    end
  endfunction

  // apply one beat to the shadow heap and return the result it must produce
  function automatic heap_result_t heap_apply(input logic op, input logic [31:0] k,
                                              input logic [8:0] pos);
    heap_result_t r;
    int unsigned  p;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  succ;
    int unsigned  last;
    logic [31:0]  t;
    bit           done;
    r = '0;
    r.status = bhpq_pkg::ST_OK;
    if (op == bhpq_pkg::OP_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.status = bhpq_pkg::ST_FULL;
      end else begin
        shadow_count++;
        shadow_keys[shadow_count] = k;
        sift_up(shadow_count);
      end
    end else if (shadow_count == 0) begin
      r.status = bhpq_pkg::ST_EMPTY;
    end else if (pos == 0 || pos > shadow_count) begin
      r.status = bhpq_pkg::ST_BAD_POS;
    end else begin
      last = shadow_count;
      r.removed_key = shadow_keys[pos];
      shadow_count--;
      // dropping the last entry needs no repair
      if (pos != last) begin
        p = pos;
        shadow_keys[p] = shadow_keys[last];
        if (p > 1 && ranks_ahead(shadow_keys[p], shadow_keys[p >> 1])) begin
          sift_up(p);
        end else begin
          // sift down: ties go to the right child, equal keys still swap
          done = 1'b0;
          while (!done) begin
            lc = 2 * p;
            rc = lc + 1;
            if (lc > shadow_count) begin
              done = 1'b1;
            end else begin
              if (rc > shadow_count) succ = lc;
              else succ = ranks_ahead(shadow_keys[lc], shadow_keys[rc]) ? lc : rc;
              if (ranks_ahead(shadow_keys[p], shadow_keys[succ])) begin
                done = 1'b1;
              end else begin
                t = shadow_keys[p];
                shadow_keys[p] = shadow_keys[succ];
                shadow_keys[succ] = t;
                p = succ;
              end
            end
          end
        end
      end
    end
    r.top_valid = (shadow_count > 0);
    r.top_key = (shadow_count > 0) ? shadow_keys[1] : 32'h0;
    r.entry_count = shadow_count[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // every accepted result beat is compared with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result beat", 32'h0, 32'h0);
      end else begin
        want_r = pending_results.pop_front();
        if (status !== want_r.status)
          flag_mismatch("status", 32'(status), 32'(want_r.status));
        if (removed_key !== want_r.removed_key)
          flag_mismatch("removed_key", removed_key, want_r.removed_key);
        if (top_valid !== want_r.top_valid)
          flag_mismatch("top_valid", 32'(top_valid), 32'(want_r.top_valid));
        if (top_key !== want_r.top_key)
          flag_mismatch("top_key", top_key, want_r.top_key);
        if (entry_count !== want_r.entry_count)
          flag_mismatch("entry_count", 32'(entry_count), 32'(want_r.entry_count));
      end
    end
  end

  // result sink: random stall per beat, long hold-off when asked
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // offer one beat; valid stays up so the next beat can follow without a gap
  task automatic push_item(input logic op, input logic [31:0] k, input logic [8:0] pos);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    key <= k;
    position <= pos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(heap_apply(op, k, pos));
    @(negedge clk);
  endtask

  // position field is don't-care for an insert, so it gets noise
  task automatic insert_key(input logic [31:0] k);
    push_item(bhpq_pkg::OP_INSERT, k, 9'($urandom_range(0, 511)));
  endtask

  task automatic remove_at(input logic [8:0] pos);
    push_item(bhpq_pkg::OP_REMOVE, $urandom, pos);
  endtask

  // drop valid and wait until every predicted result has been seen
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    logic [bhpq_pkg::APB_ADDR_W-1:0] addr;
    addr = bhpq_pkg::APB_ADDR_W'(idx * 4);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == bhpq_pkg::REG_MAX_FIRST) shadow_max_first = val[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // small keys make ties common, extremes hit the key edges
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return ($urandom_range(0, 3) == 0) ? 32'h0 : 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // occasionally run either side flat out
  task automatic shuffle_pace();
    src_burst = ($urandom_range(0, 3) == 0);
    sink_burst = ($urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // min-first corners from an empty heap
  task automatic test_directed_min();
    logic [31:0] seed_keys [7];
    seed_keys = '{32'd1, 32'd10, 32'd2, 32'd11, 32'd12, 32'd3, 32'd4};
    write_reg(bhpq_pkg::REG_MAX_FIRST, 32'h0);
    remove_at(9'd1);                        // remove on empty heap
    foreach (seed_keys[i]) insert_key(seed_keys[i]);
    remove_at(9'd4);                        // moved last entry climbs toward root
    insert_key(32'hFFFF_FFFF);
    insert_key(32'h0);                      // new key goes all the way up
    remove_at(9'd0);                        // position zero
    remove_at(9'(shadow_count + 1));        // one past the count
    remove_at(9'd511);                      // every position bit set
    remove_at(9'(shadow_count));            // last entry just dropped
    remove_at(9'd1);                        // root out, replacement sinks
    insert_key(32'd2);
    insert_key(32'd2);                      // equal keys, tie picks right child
    remove_at(9'd1);
    remove_at(9'd2);
    quiesce();
  endtask

  // unused register index is ignored, then flip to max-first on a min-ordered heap
  task automatic test_register_writes();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    insert_key(32'd5);
    quiesce();
    write_reg(bhpq_pkg::REG_MAX_FIRST, 32'h1);
    insert_key(32'hFFFF_FFFF);
    insert_key(32'hFFFF_FFFF);
    remove_at(9'd1);
    remove_at(9'(shadow_count));
    quiesce();
  endtask

  // long receiver hold-off backs up the output register and the sequencer, then the sender pauses for a drain
  task automatic test_backpressure();
    sink_hold = 300;
    src_burst = 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 2) == 0 && shadow_count > 0)
        remove_at(9'($urandom_range(1, shadow_count)));
      else insert_key(pick_key());
    end
    src_burst = 1'b0;
    quiesce();
    repeat (10) insert_key(pick_key());
    quiesce();
  endtask

  // fill to capacity, bounce off the full heap, then empty it at random positions
  task automatic test_fill_and_drain();
    int unsigned n;
    n = 0;
    while (shadow_count < HEAP_DEPTH) begin
      if (n % 40 == 0) shuffle_pace();
      insert_key(pick_key());
      n++;
    end
    insert_key(32'h0);
    insert_key(32'hFFFF_FFFF);
    insert_key($urandom);
    remove_at(9'(HEAP_DEPTH));              // highest legal position
    while (shadow_count > 0) begin
      if (n % 40 == 0) shuffle_pace();
      if ($urandom_range(0, 4) == 0) remove_at(9'(shadow_count));
      else remove_at(9'($urandom_range(1, shadow_count)));
      n++;
    end
    remove_at(9'd1);
    remove_at(9'd0);                        // empty wins over bad position
    src_burst = 1'b0;
    sink_burst = 1'b0;
    quiesce();
  endtask

  // mixed traffic in alternating orders, mostly legal removes plus noise
  task automatic test_random_mix();
    int unsigned roll;
    int unsigned ins_pct;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(bhpq_pkg::REG_MAX_FIRST, ($urandom & 32'hFFFF_FFFE) | 32'(phase % 2));
      ins_pct = (phase < 2) ? 55 : 45;
      for (int i = 0; i < 60; i++) begin
        if (i % 30 == 0) shuffle_pace();
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) insert_key(pick_key());
        else if (roll < 92 && shadow_count > 0)
          remove_at(9'($urandom_range(1, shadow_count)));
        else remove_at(9'($urandom_range(0, 511)));
      end
      src_burst = 1'b0;
      sink_burst = 1'b0;
      quiesce();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    operation = bhpq_pkg::OP_INSERT;
    key = '0;
    position = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_min();
    test_register_writes();
    test_backpressure();
    test_fill_and_drain();
    test_random_mix();

    quiesce();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> binary_heap_priority_queue.f
sv/bhpq_pkg.sv
sv/bhpq_ram.sv
sv/binary_heap_priority_queue.sv
tb/sv/binary_heap_priority_queue_tb.sv
